[rtl/sotsp_pkg.sv]
// ----------------------------------------------------------------------------
// sotsp_pkg
// Shared constants and elaboration-time functions for the screen offset to
// step pulse converter: datapath widths and the CORDIC stage angle table.
// ----------------------------------------------------------------------------
package sotsp_pkg;

  localparam int CORDIC_STAGES   = 20;
  localparam int ANGLE_FRAC_BITS = 16;

  // CORDIC x/y datapath: operands scaled by 2^PREC_SHIFT
  localparam int PREC_SHIFT = 40;
  localparam int XY_W       = 64;
  localparam int OFF_W      = 16;
  localparam int DIST_W     = 16;

  // accumulated angle in 2^-32 degree; |z| < 2^39
  localparam int Z_W = 40;

  // angle in 2^-ANGLE_FRAC_BITS degree, |angle| < 128 degree
  localparam int ANG_W  = 8 + ANGLE_FRAC_BITS;
  localparam int DIFF_W = ANG_W + 1;
  localparam int MAG_W  = DIFF_W;

  // |diff| * 160 / 2^ANGLE_FRAC_BITS, below 2^16
  localparam int V_W         = 16;
  localparam int DIV9_RECIP  = (1 << V_W) / 9;
  localparam int RECIP_W     = 13;
  localparam int Q_W         = 13;
  localparam int PULSE_W     = 13;

  localparam logic [63:0] PI_OVER_4_Q62   = 64'h03243F6A8885A309;
  localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

  // restoring division, elaboration time only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in 2^-62 radian, odd power series
  function automatic logic [63:0] atan_rad_q62(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned e;
    acc = '0;
    if (i == 0) begin
      return PI_OVER_4_Q62;
    end
    for (int k = 0; k < 32; k++) begin
      e = i * unsigned'(2 * k + 1);
      if (e <= 62) begin
        term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  // atan(2^-i) in 2^-32 degree
  function automatic logic [63:0] stage_deg_q32(input int unsigned i);
    logic [63:0] r32;
    r32 = (atan_rad_q62(i) + (64'd1 << 29)) >> 30;
    return (r32 * DEG_PER_RAD_Q24 + (64'd1 << 23)) >> 24;
  endfunction

endpackage

[rtl/screen_offset_to_step_pulses.sv]
// ----------------------------------------------------------------------------
// screen_offset_to_step_pulses
// Converts a current and a target screen point into signed microstep pulse
// counts for a two-axis gimbal, one beat per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Each input beat carries a current and a target point as signed x/y offsets
// from the screen center. For each axis the block takes atan(offset /
// screen_distance) in degrees for both points, subtracts current from target
// and scales by 32 microsteps per 1.8 degree step, truncated toward zero.
// Four parallel CORDIC pipelines (one per coordinate) do the angles; a short
// fixed-point tail does the scaling. A new beat is taken every clock unless the
// output stalls. From input acceptance to out_tvalid a beat passes one load
// stage, one stage per micro-rotation, one rounding stage, then difference,
// scale, divide-by-9 estimate and correction/output.
// The whole pipeline holds while out_tvalid is high and out_tready is low, so
// in_tready follows out_tready in that case. in_tready is low during reset.
// screen_distance (reset 1000) is sampled with each beat; write it only while
// the pipeline is empty.
// ----------------------------------------------------------------------------
module screen_offset_to_step_pulses
  import sotsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] current_x, [31:16] current_y, [47:32] target_x, [63:48] target_y
  input  logic [63:0] in_tdata,

  output logic        out_tvalid,
  input  logic        out_tready,
  // [12:0] pulses_x, [25:13] pulses_y, [31:26] zero
  output logic [31:0] out_tdata,

  input  logic                cfg_wr_en,
  input  logic [DIST_W-1:0]   cfg_wr_data
);

  localparam int VLD_LEN = CORDIC_STAGES + 6;
  localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(1000);

  // lane order: current_x, current_y, target_x, target_y
  localparam int LANES = 4;
  localparam int AXES  = 2;

  logic [DIST_W-1:0] dist_r;
  logic [VLD_LEN-1:0] vld_r;
  logic en;

  logic signed [ANG_W-1:0] ang [LANES];

  // per-axis tail registers
  logic signed [DIFF_W-1:0] diff_r   [AXES];
  logic [V_W-1:0]           v_r      [AXES];
  logic                     neg_r    [AXES];
  logic [V_W-1:0]           v2_r     [AXES];
  logic                     neg2_r   [AXES];
  logic [Q_W-1:0]           q0_r     [AXES];
  logic [PULSE_W-1:0]       pulses_r [AXES];

  logic [MAG_W-1:0]         mag      [AXES];
  logic [MAG_W+7:0]         mag160   [AXES];
  logic [V_W+RECIP_W-1:0]   recip_p  [AXES];
  logic [V_W-1:0]           q0x9     [AXES];
  logic [V_W-1:0]           rem9     [AXES];
  logic [Q_W-1:0]           q_fix    [AXES];
  logic [PULSE_W-1:0]       pulses_nxt [AXES];

  // pipeline moves unless the output beat is stuck
  assign en        = !vld_r[VLD_LEN-1] || out_tready;
  assign in_tready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_RESET;
    end else if (cfg_wr_en) begin
      dist_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLD_LEN-2:0], in_tvalid};
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sotsp_cordic u_cordic (
      .clk     (clk),
      .en      (en),
      .off_i   (in_tdata[OFF_W*g +: OFF_W]),
      .dist_i  (dist_r),
      .angle_o (ang[g])
    );
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      // |diff| * 160 = |diff| * 128 + |diff| * 32
      mag[a]    = diff_r[a][DIFF_W-1] ? MAG_W'(-diff_r[a]) : MAG_W'(diff_r[a]);
      mag160[a] = {1'b0, mag[a], 7'b0} + {3'b0, mag[a], 5'b0};
      // floor(v / 9) estimate, low by at most one
      recip_p[a] = (V_W+RECIP_W)'(v_r[a]) * (V_W+RECIP_W)'(DIV9_RECIP);
      // correction step
      q0x9[a]   = {q0_r[a], 3'b0} + V_W'(q0_r[a]);
      rem9[a]   = v2_r[a] - q0x9[a];
      q_fix[a]  = (rem9[a] >= V_W'(9)) ? q0_r[a] + Q_W'(1) : q0_r[a];
      pulses_nxt[a] = neg2_r[a] ? PULSE_W'(-q_fix[a]) : PULSE_W'(q_fix[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        diff_r[a]   <= {ang[a+2][ANG_W-1], ang[a+2]} - {ang[a][ANG_W-1], ang[a]};
        v_r[a]      <= mag160[a][ANGLE_FRAC_BITS +: V_W];
        neg_r[a]    <= diff_r[a][DIFF_W-1];
        q0_r[a]     <= recip_p[a][V_W +: Q_W];
        v2_r[a]     <= v_r[a];
        neg2_r[a]   <= neg_r[a];
        pulses_r[a] <= pulses_nxt[a];
      end
    end
  end

  assign out_tvalid = vld_r[VLD_LEN-1];
  assign out_tdata  = {{(32 - 2 * PULSE_W){1'b0}}, pulses_r[1], pulses_r[0]};

endmodule

[rtl/sotsp_cordic.sv]
// ----------------------------------------------------------------------------
// sotsp_cordic
// Pipelined CORDIC in vectoring mode: atan(offset / distance) in degrees,
// one register stage per micro-rotation plus load and rounding stages.
// ----------------------------------------------------------------------------
module sotsp_cordic
  import sotsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [OFF_W-1:0]  off_i,
  input  logic [DIST_W-1:0]        dist_i,
  output logic signed [ANG_W-1:0]  angle_o
);

  localparam logic [63:0] ROUND_HALF = 64'd1 << (31 - ANGLE_FRAC_BITS);

  logic signed [XY_W-1:0] x_r [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] y_r [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_r [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_rnd;
  logic signed [ANG_W-1:0] angle_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= {{(XY_W - DIST_W - PREC_SHIFT){1'b0}}, dist_i, {PREC_SHIFT{1'b0}}};
      y_r[0] <= {{(XY_W - OFF_W - PREC_SHIFT){off_i[OFF_W-1]}}, off_i,
                 {PREC_SHIFT{1'b0}}};
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] STAGE_ANG = Z_W'(stage_deg_q32(i));
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][XY_W-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + STAGE_ANG;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - STAGE_ANG;
        end
      end
    end
  end

  // round half up to 2^-ANGLE_FRAC_BITS degree
  assign z_rnd = z_r[CORDIC_STAGES] + Z_W'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= z_rnd[(32 - ANGLE_FRAC_BITS) +: ANG_W];
    end
  end

  assign angle_o = angle_r;

endmodule

[tb/sv/sotsp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sotsp_checker
// Watches the point and pulse streams of the converter. It tracks the screen
// distance register, predicts the pulse pair for every accepted point beat
// and compares each accepted result beat in order against that prediction.
// ----------------------------------------------------------------------------
module sotsp_checker
  import sotsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [63:0]       in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [31:0]       out_tdata,
  input  logic              cfg_wr_en,
  input  logic [DIST_W-1:0] cfg_wr_data,
  output int                n_errors,
  output int                n_waiting
);

  typedef struct {
    logic signed [PULSE_W-1:0] px;
    logic signed [PULSE_W-1:0] py;
  } pulse_pair_t;

  pulse_pair_t       pulses_due[$];
  longint            rot_deg_q32[CORDIC_STAGES];
  logic [DIST_W-1:0] distance = 16'd1000;
  int                err_cnt  = 0;

  // atan(2^-i) in 2^-32 degree, from a series in 2^-62 radian
  function automatic longint atan_pow2_deg_q32(int unsigned i);
    longint unsigned rad;
    longint unsigned term;
    longint unsigned r32;
    longint          acc;
    int unsigned     k;
    int unsigned     e;
    if (i == 0) begin
      rad = PI_OVER_4_Q62;
    end else begin
      acc = 0;
      k   = 0;
      e   = i;
      while (e <= 62) begin
        term = (64'd1 << (62 - e)) / (2 * k + 1);
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
        k = k + 1;
        e = i * (2 * k + 1);
      end
      rad = $unsigned(acc);
    end
    r32 = (rad + (64'd1 << 29)) >> 30;
    return longint'((r32 * DEG_PER_RAD_Q24 + (64'd1 << 23)) >> 24);
  endfunction

  // CORDIC vectoring: atan(offset / distance) in 2^-ANGLE_FRAC_BITS degree
  function automatic longint view_angle(logic signed [OFF_W-1:0] offset,
                                        logic [DIST_W-1:0] scr_dist);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = scr_dist;
    x = x <<< PREC_SHIFT;
    y = offset;
    y = y <<< PREC_SHIFT;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + rot_deg_q32[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - rot_deg_q32[i];
      end
    end
    return (z + (longint'(1) <<< (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
  endfunction

  // angle difference -> microsteps, 160/9 per degree, toward zero
  function automatic logic signed [PULSE_W-1:0] step_count(longint diff);
    longint unsigned mag;
    longint unsigned q;
    mag = (diff < 0) ? -diff : diff;
    q   = (mag * 64'd160) / (64'd9 << ANGLE_FRAC_BITS);
    if (diff < 0) begin
      q = -q;
    end
    return q[PULSE_W-1:0];
  endfunction

  function automatic pulse_pair_t predict_pulses(logic [63:0] beat,
                                                 logic [DIST_W-1:0] scr_dist);
    pulse_pair_t r;
    r.px = step_count(view_angle(beat[47:32], scr_dist) - view_angle(beat[15:0], scr_dist));
    r.py = step_count(view_angle(beat[63:48], scr_dist) - view_angle(beat[31:16], scr_dist));
    return r;
  endfunction

  // one line per mismatch, counted
  task automatic report(string msg);
    $display("%0t MISMATCH: %s", $time, msg);
    err_cnt++;
  endtask

  initial begin
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      rot_deg_q32[i] = atan_pow2_deg_q32(i);
    end
  end

  always @(posedge clk) begin : watch
    pulse_pair_t               want;
    logic signed [PULSE_W-1:0] got_x;
    logic signed [PULSE_W-1:0] got_y;
    if (!rst_n) begin
      distance = 16'd1000;
      pulses_due.delete();
    end else begin
      // a point beat uses the distance held before this edge
      if (in_tvalid && in_tready) begin
        pulses_due.push_back(predict_pulses(in_tdata, distance));
      end
      if (out_tvalid && out_tready) begin
        if (pulses_due.size() == 0) begin
          report($sformatf("result beat %h with no point pair pending", out_tdata));
        end else begin
          want  = pulses_due.pop_front();
          got_x = out_tdata[12:0];
          got_y = out_tdata[25:13];
          if (got_x !== want.px) begin
            report($sformatf("pulses_x expected %0d got %0d", want.px, got_x));
          end
          if (got_y !== want.py) begin
            report($sformatf("pulses_y expected %0d got %0d", want.py, got_y));
          end
          if (out_tdata[31:26] !== 6'd0) begin
            report($sformatf("pad bits expected 0 got %b", out_tdata[31:26]));
          end
        end
      end
      if (cfg_wr_en) begin
        distance = cfg_wr_data;
      end
    end
    n_errors  <= err_cnt;
    n_waiting <= pulses_due.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the screen offset to step pulse converter. Drives
// point pairs under several screen distances with random gaps and stalls on
// both streams; the checker beside the block does prediction and compare.
// ----------------------------------------------------------------------------
module tb_top
  import sotsp_pkg::*;
();

  localparam logic signed [OFF_W-1:0] OFF_MIN = 16'sh8000;
  localparam logic signed [OFF_W-1:0] OFF_MAX = 16'sh7FFF;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  // [15:0] current_x, [31:16] current_y, [47:32] target_x, [63:48] target_y
  logic [63:0]       in_tdata    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  // [12:0] pulses_x, [25:13] pulses_y, [31:26] zero
  logic [31:0]       out_tdata;
  logic              cfg_wr_en   = 1'b0;
  logic [DIST_W-1:0] cfg_wr_data = '0;

  int n_errors;
  int n_waiting;

  // calm flags give stretches with no idling on each side
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  int beats_taken = 0;

  screen_offset_to_step_pulses dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  sotsp_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .n_errors   (n_errors),
    .n_waiting  (n_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; slowest legal run is well under a tenth of this
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // wait cycles before a beat: 0..16, or 0 throughout a calm stretch
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // mix of full range, near the screen distance, and around center
  function automatic logic signed [OFF_W-1:0] pick_offset(logic [DIST_W-1:0] scr_dist);
    int span;
    span = (scr_dist == 0) ? 64 : ((scr_dist > 16383) ? 32767 : 2 * scr_dist);
    case ($urandom_range(0, 3))
      0: return OFF_W'($urandom);
      1: return OFF_W'(int'($urandom_range(0, 64)) - 32);
      default: return OFF_W'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // one point beat; tvalid stays up across back-to-back beats
  task automatic offer_points(logic signed [OFF_W-1:0] cur_x, logic signed [OFF_W-1:0] cur_y,
                              logic signed [OFF_W-1:0] tgt_x, logic signed [OFF_W-1:0] tgt_y);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tgt_y, tgt_x, cur_y, cur_x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_points(int count, logic [DIST_W-1:0] scr_dist);
    repeat (count) begin
      offer_points(pick_offset(scr_dist), pick_offset(scr_dist),
                   pick_offset(scr_dist), pick_offset(scr_dist));
    end
  endtask

  // the register is sampled per beat, so only change it with the pipe empty;
  // n_waiting is registered, hence the leading clock before the test
  task automatic drain_and_set_distance(logic [DIST_W-1:0] scr_dist);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= scr_dist;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // result side: random stall per beat, plus two long hold-offs so the
  // pipeline fills and in_tready drops while points keep coming
  initial begin : result_side
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(rx_calm);
      if (beats_taken == 300 || beats_taken == 900) begin
        stall = 400;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      beats_taken++;
    end
  end

  initial begin : point_side
    int plan[6];
    int wait_cycles;
    plan = '{1, 65535, 0, $urandom_range(2, 65534), 1000, $urandom_range(2, 65534)};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset distance of 1000
    offer_points(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    offer_points(OFF_MIN, OFF_MIN, OFF_MAX, OFF_MAX);   // full swing, both axes
    offer_points(OFF_MAX, OFF_MAX, OFF_MIN, OFF_MIN);
    offer_points(OFF_MAX, OFF_MIN, OFF_MAX, OFF_MIN);   // same point twice
    offer_points(16'sd0, 16'sd0, OFF_MAX, OFF_MIN);
    offer_points(16'sd0, 16'sd0, 16'sd1, -16'sd1);      // smallest moves
    offer_points(-16'sd1, 16'sd1, 16'sd0, 16'sd0);
    offer_points(16'sd0, 16'sd0, 16'sd1000, -16'sd1000); // 45 degrees
    offer_points(-16'sd1000, 16'sd1000, 16'sd1000, -16'sd1000);
    offer_points(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);
    random_points(180, 16'd1000);

    // distance sweep: smallest, largest, zero (about +-90 degrees for any
    // nonzero offset), random ones and the reset value written back
    foreach (plan[p]) begin
      drain_and_set_distance(DIST_W'(plan[p]));
      offer_points(OFF_MIN, OFF_MAX, OFF_MAX, OFF_MIN);
      offer_points(16'sd0, 16'sd0, OFF_MAX, OFF_MIN);
      offer_points(-16'sd1, 16'sd1, 16'sd1, -16'sd1);
      offer_points(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      random_points(170, DIST_W'(plan[p]));
    end
    in_tvalid <= 1'b0;

    // drain, bounded, then a pipeline's worth of quiet cycles
    @(posedge clk);
    for (wait_cycles = 0; n_waiting != 0 && wait_cycles < 5000; wait_cycles++) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    if (n_errors == 0 && n_waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
